/* src/stdd_pkg.sv */
// ----------------------------------------------------------------------------
// stdd_pkg
// Shared widths and control types of the tile distance and direction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stdd_pkg;

    // signed pixel difference, sized for tile sides up to 256
    localparam int DELTA_W = 27;
    // magnitude of one pixel difference
    localparam int MAG_W   = 24;
    // square of one magnitude
    localparam int SQ_W    = 2 * MAG_W;
    // sum of both squares
    localparam int SUM_W   = SQ_W + 1;
    // quotient mag^2 * 2^32 / sum, at most 2^32
    localparam int Q_W     = 33;
    // radicand width of the shared root pipelines (even)
    localparam int RAD_W   = SUM_W + 1;
    // root width of those pipelines
    localparam int ROOT_W  = RAD_W / 2;
    // reduced root for the Q1.15 component, at most 32768
    localparam int RND_W   = 17;
    // output field widths
    localparam int DIST_W  = 23;
    localparam int DIR_W   = 16;
    localparam int COORD_W = 22;
    localparam int TILE_W  = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [DIR_W-1:0]  DIR_MAX  = {1'b0, {(DIR_W-1){1'b1}}};

    // operation codes
    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_TILE   = 2'd1,
        OP_SQUARE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // control group leaving the front end
    typedef struct packed {
        logic range_err;
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_ctl;

endpackage

`default_nettype wire

/* src/stdd_front.sv */
// ----------------------------------------------------------------------------
// stdd_front
// Three-stage front end: pixel differences, magnitudes squared, their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module stdd_front #(
    parameter int TILE_WIDTH  = 32,
    parameter int TILE_HEIGHT = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_vld,
    input  wire  [1:0]                   i_op,
    input  wire  [stdd_pkg::COORD_W-1:0] i_start_x,
    input  wire  [stdd_pkg::COORD_W-1:0] i_start_y,
    input  wire  [stdd_pkg::COORD_W-1:0] i_end_x,
    input  wire  [stdd_pkg::COORD_W-1:0] i_end_y,
    output logic                         o_vld,
    output stdd_pkg::t_ctl               o_ctl,
    output logic [stdd_pkg::SUM_W-1:0]   o_sum,
    output logic [stdd_pkg::SQ_W-1:0]    o_sq_x,
    output logic [stdd_pkg::SQ_W-1:0]    o_sq_y
);
    import stdd_pkg::*;

    localparam logic [DELTA_W-1:0] W_K  = DELTA_W'(TILE_WIDTH);
    localparam logic [DELTA_W-1:0] HW_K = DELTA_W'(TILE_WIDTH / 2);
    localparam logic [DELTA_W-1:0] H_K  = DELTA_W'(TILE_HEIGHT);
    localparam logic [DELTA_W-1:0] HH_K = DELTA_W'(TILE_HEIGHT / 2);

    logic                       in_range;
    logic        [DELTA_W-1:0]  u_sx, u_sy, u_ex, u_ey;
    logic        [DELTA_W-1:0]  u_spx, u_epx, u_spy, u_epy;
    logic signed [DELTA_W-1:0]  diff_x, diff_y, sq_dx, v_y;
    logic signed [DELTA_W-1:0]  n_dx, n_dy;
    logic                       n_range;

    logic signed [DELTA_W-1:0]  r_dx, r_dy;
    logic                       r_range1, r_vld1;
    logic        [MAG_W-1:0]    mag_x, mag_y;
    logic        [SQ_W-1:0]     r_sq_x2, r_sq_y2;
    logic                       r_neg_x2, r_neg_y2, r_range2, r_vld2;

    // stage 1: pixel differences per mode
    always_comb begin
        in_range = ~(|i_start_x[COORD_W-1:TILE_W]) & ~(|i_start_y[COORD_W-1:TILE_W])
                 & ~(|i_end_x[COORD_W-1:TILE_W]) & ~(|i_end_y[COORD_W-1:TILE_W]);
        u_sx = DELTA_W'(i_start_x);
        u_sy = DELTA_W'(i_start_y);
        u_ex = DELTA_W'(i_end_x);
        u_ey = DELTA_W'(i_end_y);
        diff_x = $signed(u_ex) - $signed(u_sx);
        diff_y = $signed(u_ey) - $signed(u_sy);
        // tile centres in pixels
        u_spx = u_sx * W_K + HW_K + (i_start_y[0] ? HW_K : '0);
        u_epx = u_ex * W_K + HW_K + (i_end_y[0] ? HW_K : '0);
        u_spy = ((u_sy * H_K) >> 1) + HH_K;
        u_epy = ((u_ey * H_K) >> 1) + HH_K;
        // square-tile variant, halving truncated toward zero
        sq_dx = diff_x * $signed(W_K);
        if (i_end_y[0] && !i_start_y[0]) begin
            sq_dx = sq_dx + $signed(HW_K);
        end else if (!i_end_y[0] && i_start_y[0]) begin
            sq_dx = sq_dx - $signed(HW_K);
        end
        v_y = diff_y * $signed(W_K);
        n_dx = '0;
        n_dy = '0;
        n_range = 1'b0;
        case (t_op'(i_op))
            OP_PIXEL: begin
                n_dx = diff_x;
                n_dy = diff_y;
            end
            OP_TILE: begin
                if (in_range) begin
                    n_dx = $signed(u_epx) - $signed(u_spx);
                    n_dy = $signed(u_epy) - $signed(u_spy);
                end else begin
                    n_range = 1'b1;
                end
            end
            OP_SQUARE: begin
                if (in_range) begin
                    n_dx = sq_dx;
                    n_dy = (v_y >>> 1) + $signed(DELTA_W'(v_y[DELTA_W-1] & v_y[0]));
                end else begin
                    n_range = 1'b1;
                end
            end
            default: begin
                n_dx = '0;
                n_dy = '0;
            end
        endcase
    end

    // stage 2: magnitudes
    always_comb begin
        mag_x = MAG_W'(r_dx[DELTA_W-1] ? -r_dx : r_dx);
        mag_y = MAG_W'(r_dy[DELTA_W-1] ? -r_dy : r_dy);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            o_vld  <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            o_vld  <= r_vld2;
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_range1 <= n_range;
            r_sq_x2  <= SQ_W'(mag_x * mag_x);
            r_sq_y2  <= SQ_W'(mag_y * mag_y);
            r_neg_x2 <= r_dx[DELTA_W-1];
            r_neg_y2 <= r_dy[DELTA_W-1];
            r_range2 <= r_range1;
            o_sum    <= SUM_W'(r_sq_x2) + SUM_W'(r_sq_y2);
            o_sq_x   <= r_sq_x2;
            o_sq_y   <= r_sq_y2;
            o_ctl.range_err <= r_range2;
            o_ctl.zero      <= (r_sq_x2 == '0) && (r_sq_y2 == '0);
            o_ctl.neg_x     <= r_neg_x2;
            o_ctl.neg_y     <= r_neg_y2;
        end
    end

endmodule

`default_nettype wire

/* src/stdd_div.sv */
// ----------------------------------------------------------------------------
// stdd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stdd_div #(
    parameter int DW = 49,
    parameter int QW = 33,
    parameter int PW = 1
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_en,
    input  wire           i_vld,
    input  wire  [DW-1:0] i_rem,
    input  wire  [QW-1:0] i_low,
    input  wire  [DW-1:0] i_den,
    input  wire  [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [QW-1:0] o_quot,
    output logic [PW-1:0] o_pay
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];
    logic [PW-1:0] r_pay [QW];
    logic          r_vld [QW];

    logic [DW-1:0] s_rem [QW];
    logic [QW-1:0] s_low [QW];
    logic [QW-1:0] s_q   [QW];
    logic [DW-1:0] s_den [QW];
    logic [PW-1:0] s_pay [QW];
    logic          s_vld [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW:0] rem2;
        logic [DW:0] diff;

        // stage inputs
        if (g == 0) begin : g_first
            assign s_rem[g] = i_rem;
            assign s_low[g] = i_low;
            assign s_q[g]   = '0;
            assign s_den[g] = i_den;
            assign s_pay[g] = i_pay;
            assign s_vld[g] = i_vld;
        end else begin : g_next
            assign s_rem[g] = r_rem[g-1];
            assign s_low[g] = r_low[g-1];
            assign s_q[g]   = r_q[g-1];
            assign s_den[g] = r_den[g-1];
            assign s_pay[g] = r_pay[g-1];
            assign s_vld[g] = r_vld[g-1];
        end

        // trial subtract
        always_comb begin
            rem2 = {s_rem[g], s_low[g][QW-1]};
            diff = rem2 - {1'b0, s_den[g]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem2 >= {1'b0, s_den[g]}) begin
                    r_rem[g] <= diff[DW-1:0];
                    r_q[g]   <= {s_q[g][QW-2:0], 1'b1};
                end else begin
                    r_rem[g] <= rem2[DW-1:0];
                    r_q[g]   <= {s_q[g][QW-2:0], 1'b0};
                end
                r_low[g] <= {s_low[g][QW-2:0], 1'b0};
                r_den[g] <= s_den[g];
                r_pay[g] <= s_pay[g];
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quot = r_q[QW-1];
    assign o_pay  = r_pay[QW-1];

endmodule

`default_nettype wire

/* src/stdd_isqrt.sv */
// ----------------------------------------------------------------------------
// stdd_isqrt
// Pipelined integer square root, two radicand bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stdd_isqrt #(
    parameter int W  = 50,
    parameter int PW = 1
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_vld,
    input  wire  [W-1:0]     i_rad,
    input  wire  [PW-1:0]    i_pay,
    output logic             o_vld,
    output logic [W/2-1:0]   o_root,
    output logic [PW-1:0]    o_pay
);

    localparam int STG  = W / 2;
    localparam int RW   = W / 2;
    localparam int REMW = RW + 2;

    logic [REMW-1:0] r_rem  [STG];
    logic [RW-1:0]   r_root [STG];
    logic [W-1:0]    r_rad  [STG];
    logic [PW-1:0]   r_pay  [STG];
    logic            r_vld  [STG];

    logic [REMW-1:0] s_rem  [STG];
    logic [RW-1:0]   s_root [STG];
    logic [W-1:0]    s_rad  [STG];
    logic [PW-1:0]   s_pay  [STG];
    logic            s_vld  [STG];

    for (genvar g = 0; g < STG; g++) begin : g_stage
        logic [REMW-1:0] rem2;
        logic [REMW-1:0] trial;

        // stage inputs
        if (g == 0) begin : g_first
            assign s_rem[g]  = '0;
            assign s_root[g] = '0;
            assign s_rad[g]  = i_rad;
            assign s_pay[g]  = i_pay;
            assign s_vld[g]  = i_vld;
        end else begin : g_next
            assign s_rem[g]  = r_rem[g-1];
            assign s_root[g] = r_root[g-1];
            assign s_rad[g]  = r_rad[g-1];
            assign s_pay[g]  = r_pay[g-1];
            assign s_vld[g]  = r_vld[g-1];
        end

        // bring in two bits and try the next root bit
        always_comb begin
            rem2  = {s_rem[g][REMW-3:0], s_rad[g][W-1:W-2]};
            trial = {s_root[g], 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem2 >= trial) begin
                    r_rem[g]  <= rem2 - trial;
                    r_root[g] <= {s_root[g][RW-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= rem2;
                    r_root[g] <= {s_root[g][RW-2:0], 1'b0};
                end
                r_rad[g] <= {s_rad[g][W-3:0], 2'b00};
                r_pay[g] <= s_pay[g];
            end
        end
    end

    assign o_vld  = r_vld[STG-1];
    assign o_root = r_root[STG-1];
    assign o_pay  = r_pay[STG-1];

endmodule

`default_nettype wire

/* src/staggered_tile_distance_direction_unit.sv */
// ----------------------------------------------------------------------------
// staggered_tile_distance_direction_unit
// Distance and Q1.15 unit direction between two pixel or tile positions.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one position pair per transfer: tdata holds the
//   start and end coordinates, tuser the mode (pixel, tile centre, square
//   tile). The master channel returns one result per pair, in order: tdata
//   holds distance and both direction components, tuser the range error flag.
//   From an accepted transfer to its result the data pass through three front
//   stages, 33 divider stages (one quotient bit each), 25 root stages (two
//   radicand bits each) and the output register. One pair is taken in every
//   cycle while the output is free or being taken.
//   A stalled receiver freezes the whole pipeline, so input ready falls in
//   the same cycle; nothing is lost or repeated.
//   Reset clears every valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_tile_distance_direction_unit #(
    parameter int TILE_WIDTH  = 32,
    parameter int TILE_HEIGHT = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // start_x[21:0], start_y[43:22], end_x[65:44], end_y[87:66]
    input  wire  [87:0] i_s_tdata,
    // op[1:0]
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // distance[22:0], dir_x[38:23], dir_y[54:39], zero fill[55]
    output logic [55:0] o_m_tdata,
    // range_error[0]
    output logic [0:0]  o_m_tuser
);
    import stdd_pkg::*;

    logic                en;
    logic                f_vld;
    t_ctl                f_ctl;
    logic [SUM_W-1:0]    f_sum;
    logic [SQ_W-1:0]     f_sq_x, f_sq_y;

    logic                dx_vld;
    logic [Q_W-1:0]      q_x, q_y;
    logic [SUM_W+2:0]    dx_pay;
    logic                dy_pay;
    logic [SUM_W-1:0]    d_sum;

    logic                rt_vld;
    logic [ROOT_W-1:0]   root_d, root_x, root_y;
    logic [1:0]          rt_pay;
    logic                rx_neg, ry_neg;

    logic [ROOT_W:0]     kx1, ky1;
    logic [DIST_W-1:0]   n_dist;
    logic [DIR_W-1:0]    n_dir_x, n_dir_y;

    logic                r_out_vld;
    logic [DIST_W-1:0]   r_dist;
    logic [DIR_W-1:0]    r_dir_x, r_dir_y;
    logic                r_range;

    // signed, saturated Q1.15 component from the rounded magnitude
    function automatic logic [DIR_W-1:0] dir_of(input logic [RND_W-1:0] mag,
                                               input logic neg, input logic zero);
        logic [DIR_W-1:0] res;
        if (zero) begin
            res = '0;
        end else if (neg) begin
            res = DIR_W'(~mag + RND_W'(1));
        end else if (mag > RND_W'(DIR_MAX)) begin
            res = DIR_MAX;
        end else begin
            res = mag[DIR_W-1:0];
        end
        return res;
    endfunction

    // whole pipeline advances while the output register is free or taken
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    stdd_front #(
        .TILE_WIDTH (TILE_WIDTH),
        .TILE_HEIGHT(TILE_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_s_tvalid),
        .i_op     (i_s_tuser),
        .i_start_x(i_s_tdata[21:0]),
        .i_start_y(i_s_tdata[43:22]),
        .i_end_x  (i_s_tdata[65:44]),
        .i_end_y  (i_s_tdata[87:66]),
        .o_vld    (f_vld),
        .o_ctl    (f_ctl),
        .o_sum    (f_sum),
        .o_sq_x   (f_sq_x),
        .o_sq_y   (f_sq_y)
    );

    // quotients mag^2 * 2^32 / sum for both axes
    stdd_div #(.DW(SUM_W), .QW(Q_W), .PW(SUM_W + 3)) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (f_vld),
        .i_rem  (SUM_W'(f_sq_x[SQ_W-1:1])),
        .i_low  ({f_sq_x[0], (Q_W-1)'(0)}),
        .i_den  (f_sum),
        .i_pay  ({f_sum, f_ctl.range_err, f_ctl.zero, f_ctl.neg_x}),
        .o_vld  (dx_vld),
        .o_quot (q_x),
        .o_pay  (dx_pay)
    );

    stdd_div #(.DW(SUM_W), .QW(Q_W), .PW(1)) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (f_vld),
        .i_rem  (SUM_W'(f_sq_y[SQ_W-1:1])),
        .i_low  ({f_sq_y[0], (Q_W-1)'(0)}),
        .i_den  (f_sum),
        .i_pay  (f_ctl.neg_y),
        .o_vld  (),
        .o_quot (q_y),
        .o_pay  (dy_pay)
    );

    assign d_sum = dx_pay[SUM_W+2:3];

    // distance root and the two component roots, all of equal depth
    stdd_isqrt #(.W(RAD_W), .PW(2)) u_root_d (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (dx_vld),
        .i_rad  (RAD_W'(d_sum)),
        .i_pay  (dx_pay[2:1]),
        .o_vld  (rt_vld),
        .o_root (root_d),
        .o_pay  (rt_pay)
    );

    stdd_isqrt #(.W(RAD_W), .PW(1)) u_root_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (dx_vld),
        .i_rad  (RAD_W'(q_x)),
        .i_pay  (dx_pay[0]),
        .o_vld  (),
        .o_root (root_x),
        .o_pay  (rx_neg)
    );

    stdd_isqrt #(.W(RAD_W), .PW(1)) u_root_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (dx_vld),
        .i_rad  (RAD_W'(q_y)),
        .i_pay  (dy_pay),
        .o_vld  (),
        .o_root (root_y),
        .o_pay  (ry_neg)
    );

    // rounding, saturation and sign
    always_comb begin
        kx1 = {1'b0, root_x} + (ROOT_W+1)'(1);
        ky1 = {1'b0, root_y} + (ROOT_W+1)'(1);
        n_dir_x = dir_of(kx1[RND_W:1], rx_neg, rt_pay[0]);
        n_dir_y = dir_of(ky1[RND_W:1], ry_neg, rt_pay[0]);
        if (root_d > ROOT_W'(DIST_MAX)) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = root_d[DIST_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= rt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist  <= n_dist;
            r_dir_x <= n_dir_x;
            r_dir_y <= n_dir_y;
            r_range <= rt_pay[1];
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = {1'b0, r_dir_y, r_dir_x, r_dist};
    assign o_m_tuser[0] = r_range;

`ifndef SYNTHESIS
    // a range error carries an all-zero result
    a_range_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("range error with non-zero result");

    // zero distance means a zero direction
    a_zero_dir : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[22:0] == '0 |-> o_m_tdata[54:23] == '0)
        else $error("zero distance with non-zero direction");

    // a waiting result blocks the input side
    a_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input ready during output stall");

    // a stalled result is held by the output register
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
